### design/atl_pkg.sv
// Package for the assembly token lexer: lexer state and token kind enums,
// the token record, character constants and character class helpers.
// No dependencies.
package atl_pkg;

  localparam int unsigned ValueBitsDefault = 32;
  localparam int unsigned TokValueBits     = 32;
  localparam int unsigned FifoDepth        = 4;

  localparam logic [7:0] CharHash    = 8'h23;  // '#'
  localparam logic [7:0] CharComma   = 8'h2C;  // ','
  localparam logic [7:0] CharZero    = 8'h30;  // '0'
  localparam logic [7:0] CharOne     = 8'h31;  // '1'
  localparam logic [7:0] CharFive    = 8'h35;  // '5'
  localparam logic [7:0] CharNine    = 8'h39;  // '9'
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CaseOffset  = 8'h20;  // upper to lower case

  localparam logic [3:0] RegTenBase = 4'd10;

  localparam logic [TokValueBits-1:0] MnemMov = 32'd0;
  localparam logic [TokValueBits-1:0] MnemAdd = 32'd1;
  localparam logic [TokValueBits-1:0] MnemSub = 32'd2;

  typedef enum logic [3:0] {
    ST_START   = 4'd0,
    ST_HASH    = 4'd1,
    ST_VALUE   = 4'd2,
    ST_R       = 4'd3,
    ST_R1      = 4'd4,
    ST_REGDONE = 4'd5,
    ST_M       = 4'd6,
    ST_MO      = 4'd7,
    ST_MOV     = 4'd8,
    ST_A       = 4'd9,
    ST_AD      = 4'd10,
    ST_ADD     = 4'd11,
    ST_S       = 4'd12,
    ST_SU      = 4'd13,
    ST_SUB     = 4'd14,
    ST_ERROR   = 4'd15
  } lex_state_e;

  typedef enum logic [2:0] {
    TK_COMMA = 3'd0,
    TK_IMM   = 3'd1,
    TK_REG   = 3'd2,
    TK_MNEM  = 3'd3,
    TK_END   = 3'd4,
    TK_ERR   = 3'd5
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e                kind;
    logic [TokValueBits-1:0]  value;
    logic                     last;
  } token_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CharSpace) || (c == CharNewline);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic logic is_letter(input logic [7:0] c, input logic [7:0] upper);
    return (c == upper) || (c == upper + CaseOffset);
  endfunction

endpackage

### design/assembly_token_lexer.sv
// Assembly token lexer top level: input register, lexer core, result queue.
// Depends on atl_pkg, atl_core and atl_out_fifo.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------------------
//   in      | sink      | in_valid_i / in_stall_o   | kind_i, character_i
//   out     | source    | out_valid_o / out_stall_i | token_kind_o, token_value_o, last_o
//
// One input transaction per cycle sustained while the queue has room; a token
// passes through the input register, then the result queue, before it leaves.
// The "r1," case yields two tokens and so leaves as two output transactions; the
// four-entry result queue absorbs it and the input stalls only when fewer
// than two queue entries are free.
// Reset clears the lexer to its start state, the accumulator, the input
// register valid and the queue. Stalls on the output never drop or repeat a
// token.
module assembly_token_lexer import atl_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    kind_i,
  input  logic [7:0]              character_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [2:0]              token_kind_o,
  output logic [TokValueBits-1:0] token_value_o,
  output logic                    last_o
);

  logic          in_vld_q, in_vld_d;
  logic          kind_q;
  logic [7:0]    char_q;
  logic          load;
  logic          step;
  logic          room;
  logic [1:0]    tok_cnt;
  logic [1:0]    push_cnt;
  token_t [1:0]  tok;
  token_t        head;

  // hold the registered item until the queue has room for both its tokens
  assign step       = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;
  assign load       = in_valid_i && !in_stall_o;
  assign push_cnt   = step ? tok_cnt : 2'd0;

  always_comb begin
    in_vld_d = in_vld_q;
    if (load)      in_vld_d = 1'b1;
    else if (step) in_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_vld_q <= 1'b0;
    else         in_vld_q <= in_vld_d;
  end

  // payload register: no reset needed
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_i;
      char_q <= character_i;
    end
  end

  atl_core #(
    .VALUE_BITS(VALUE_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .kind_i    (kind_q),
    .char_i    (char_q),
    .tok_cnt_o (tok_cnt),
    .tok_o     (tok)
  );

  atl_out_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push_tok_i (tok),
    .pop_i      (out_valid_o && !out_stall_i),
    .room_o     (room),
    .valid_o    (out_valid_o),
    .head_o     (head)
  );

  assign token_kind_o  = head.kind;
  assign token_value_o = head.value;
  assign last_o        = head.last;

endmodule

### design/atl_core.sv
// Lexer state machine and immediate accumulator: steps one registered item
// and produces up to two tokens. Depends on atl_pkg.
module atl_core import atl_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            kind_i,
  input  logic [7:0]      char_i,
  output logic [1:0]      tok_cnt_o,
  output token_t [1:0]    tok_o
);

  localparam int unsigned ExtW = (VALUE_BITS > TokValueBits) ? VALUE_BITS : TokValueBits;

  lex_state_e             state_q, state_d;
  logic [VALUE_BITS-1:0]  acc_q, acc_d;
  logic [VALUE_BITS-1:0]  acc_base;
  logic [VALUE_BITS+3:0]  acc_wide;
  logic [VALUE_BITS+3:0]  prod;
  logic                   ovf;
  logic [ExtW-1:0]        acc_ext;
  logic [TokValueBits-1:0] imm_val;

  // acc*10 + digit by shifts; overflow when anything lands above VALUE_BITS
  assign acc_base = (state_q == ST_HASH) ? '0 : acc_q;
  assign acc_wide = {4'b0000, acc_base};
  assign prod     = (acc_wide << 3) + (acc_wide << 1) + (VALUE_BITS+4)'(char_i[3:0]);
  assign ovf      = |prod[VALUE_BITS+3:VALUE_BITS];
  assign acc_ext  = ExtW'(acc_q);
  assign imm_val  = acc_ext[TokValueBits-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    if (step_i) begin
      if (kind_i) begin
        state_d = ST_START;
        acc_d   = '0;
      end else begin
        unique case (state_q)
          ST_START: begin
            if (char_i == CharHash) begin
              state_d = ST_HASH;
              acc_d   = '0;
            end else if (is_letter(char_i, "M")) state_d = ST_M;
            else if (is_letter(char_i, "R")) state_d = ST_R;
            else if (is_letter(char_i, "A")) state_d = ST_A;
            else if (is_letter(char_i, "S")) state_d = ST_S;
            else if (char_i == CharComma || is_space(char_i)) state_d = ST_START;
            else state_d = ST_ERROR;
          end
          ST_HASH, ST_VALUE: begin
            if (is_digit(char_i)) begin
              state_d = ST_VALUE;
              acc_d   = ovf ? '1 : prod[VALUE_BITS-1:0];
            end else if (state_q == ST_VALUE && is_space(char_i)) begin
              state_d = ST_START;
              acc_d   = '0;
            end else begin
              state_d = ST_ERROR;
            end
          end
          ST_R: begin
            if (char_i == CharOne) state_d = ST_R1;
            else if (is_digit(char_i)) state_d = ST_START;
            else state_d = ST_ERROR;
          end
          ST_R1: begin
            if (char_i >= CharZero && char_i <= CharFive) state_d = ST_REGDONE;
            else if (char_i == CharComma || is_space(char_i)) state_d = ST_START;
            else state_d = ST_ERROR;
          end
          ST_REGDONE: begin
            if (char_i == CharComma || is_space(char_i)) state_d = ST_START;
            else state_d = ST_ERROR;
          end
          ST_M:  state_d = is_letter(char_i, "O") ? ST_MO  : ST_ERROR;
          ST_MO: state_d = is_letter(char_i, "V") ? ST_MOV : ST_ERROR;
          ST_A:  state_d = is_letter(char_i, "D") ? ST_AD  : ST_ERROR;
          ST_AD: state_d = is_letter(char_i, "D") ? ST_ADD : ST_ERROR;
          ST_S:  state_d = is_letter(char_i, "U") ? ST_SU  : ST_ERROR;
          ST_SU: state_d = is_letter(char_i, "B") ? ST_SUB : ST_ERROR;
          ST_MOV, ST_ADD, ST_SUB: state_d = is_space(char_i) ? ST_START : ST_ERROR;
          ST_ERROR: state_d = ST_ERROR;
          default:  state_d = ST_ERROR;
        endcase
        if (state_d == ST_ERROR) acc_d = '0;
      end
    end
  end

  // token outputs
  always_comb begin
    tok_cnt_o      = 2'd0;
    tok_o[0].kind  = TK_ERR;
    tok_o[0].value = '0;
    tok_o[0].last  = 1'b1;
    tok_o[1].kind  = TK_COMMA;
    tok_o[1].value = '0;
    tok_o[1].last  = 1'b1;
    if (kind_i) begin
      tok_cnt_o     = 2'd1;
      tok_o[0].kind = TK_END;
    end else begin
      unique case (state_q)
        ST_START: begin
          if (char_i == CharComma) begin
            tok_cnt_o     = 2'd1;
            tok_o[0].kind = TK_COMMA;
          end else if (!(char_i == CharHash || is_letter(char_i, "M") ||
                         is_letter(char_i, "R") || is_letter(char_i, "A") ||
                         is_letter(char_i, "S") || is_space(char_i))) begin
            tok_cnt_o = 2'd1;
          end
        end
        ST_HASH: if (!is_digit(char_i)) tok_cnt_o = 2'd1;
        ST_VALUE: begin
          if (is_space(char_i)) begin
            tok_cnt_o      = 2'd1;
            tok_o[0].kind  = TK_IMM;
            tok_o[0].value = imm_val;
          end else if (!is_digit(char_i)) begin
            tok_cnt_o = 2'd1;
          end
        end
        ST_R: begin
          if (is_digit(char_i) && char_i != CharOne) begin
            tok_cnt_o      = 2'd1;
            tok_o[0].kind  = TK_REG;
            tok_o[0].value = TokValueBits'(char_i[3:0]);
          end else if (!is_digit(char_i)) begin
            tok_cnt_o = 2'd1;
          end
        end
        ST_R1: begin
          tok_cnt_o      = 2'd1;
          tok_o[0].kind  = TK_REG;
          tok_o[0].value = TokValueBits'(4'd1);
          if (char_i >= CharZero && char_i <= CharFive) begin
            tok_o[0].value = TokValueBits'(RegTenBase + char_i[3:0]);
          end else if (char_i == CharComma) begin
            tok_cnt_o     = 2'd2;
            tok_o[0].last = 1'b0;
          end else if (!is_space(char_i)) begin
            tok_o[0].kind  = TK_ERR;
            tok_o[0].value = '0;
          end
        end
        ST_REGDONE: begin
          if (char_i == CharComma) begin
            tok_cnt_o     = 2'd1;
            tok_o[0].kind = TK_COMMA;
          end else if (!is_space(char_i)) begin
            tok_cnt_o = 2'd1;
          end
        end
        ST_M:  if (!is_letter(char_i, "O")) tok_cnt_o = 2'd1;
        ST_MO: if (!is_letter(char_i, "V")) tok_cnt_o = 2'd1;
        ST_A:  if (!is_letter(char_i, "D")) tok_cnt_o = 2'd1;
        ST_AD: if (!is_letter(char_i, "D")) tok_cnt_o = 2'd1;
        ST_S:  if (!is_letter(char_i, "U")) tok_cnt_o = 2'd1;
        ST_SU: if (!is_letter(char_i, "B")) tok_cnt_o = 2'd1;
        ST_MOV, ST_ADD, ST_SUB: begin
          tok_cnt_o = 2'd1;
          if (is_space(char_i)) begin
            tok_o[0].kind  = TK_MNEM;
            tok_o[0].value = (state_q == ST_MOV) ? MnemMov :
                             (state_q == ST_ADD) ? MnemAdd : MnemSub;
          end
        end
        ST_ERROR: tok_cnt_o = 2'd0;
        default:  tok_cnt_o = 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
    end
  end

endmodule

### design/atl_out_fifo.sv
// Result queue: takes up to two tokens per cycle, hands out one per
// transaction. Depends on atl_pkg.
module atl_out_fifo import atl_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_cnt_i,
  input  token_t [1:0]  push_tok_i,
  input  logic          pop_i,
  output logic          room_o,
  output logic          valid_o,
  output token_t        head_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  token_t             mem_q [FifoDepth];
  logic [PtrW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [PtrW-1:0]    wr_next;

  assign wr_next = wr_q + PtrW'(1);
  // room for two tokens regardless of the pop this cycle
  assign room_o  = cnt_q <= CntW'(FifoDepth - 2);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q + PtrW'(push_cnt_i);
    rd_d  = pop_i ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'(push_cnt_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_q]    <= push_tok_i[0];
    if (push_cnt_i == 2'd2) mem_q[wr_next] <= push_tok_i[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### design/atl_checker.sv
// Port-level checks for the assembly token lexer, bound to the top level.
// Depends on atl_pkg.
module atl_checker import atl_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [2:0]              token_kind_o,
  input logic [TokValueBits-1:0] token_value_o,
  input logic                    last_o
);

  // a stalled result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(token_value_o) && $stable(last_o))
    else $error("stalled result changed");

  // only a register token can be followed by another from the same item
  a_last_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != TK_REG |-> last_o)
    else $error("non-register token without last");

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == TK_COMMA || token_kind_o == TK_END ||
      token_kind_o == TK_ERR) |-> token_value_o == '0)
    else $error("comma, end or error token with a value");

  a_reg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == TK_REG |-> token_value_o <= TokValueBits'(15))
    else $error("register number out of range");

endmodule

bind assembly_token_lexer atl_checker u_atl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .token_kind_o  (token_kind_o),
  .token_value_o (token_value_o),
  .last_o        (last_o)
);
